/* src/ipv4p_pkg.sv */
package ipv4p_pkg;

    // link mode register codes
    localparam logic [1:0] LINK_ETH = 2'd0;
    localparam logic [1:0] LINK_RAW = 2'd1;

    // protocol classes on the result
    localparam logic [1:0] CLASS_TCP   = 2'd0;
    localparam logic [1:0] CLASS_UDP   = 2'd1;
    localparam logic [1:0] CLASS_ICMP  = 2'd2;
    localparam logic [1:0] CLASS_OTHER = 2'd3;

    // IPv4 protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [15:0] ETH_HDR_LEN = 16'd14;
    localparam logic [7:0]  UDP_HDR_LEN = 8'd8;

    // register index taken from the word address
    localparam logic CFG_IDX_LINK_MODE = 1'b0;

    localparam int MAX_OFFSET = 134;

    // per-byte control from the handshake side to the capture logic
    typedef struct packed {
        logic step;     // a request is processed this cycle
        logic last;     // final byte of the packet
        logic capture;  // link mode is supported, fields are taken
        logic eth;      // ethernet header precedes the ip header
    } t_step_ctrl;

    typedef struct packed {
        logic [1:0]  proto_class;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [5:0]  tcp_flag_bits;
        logic [31:0] tcp_seq;
        logic [7:0]  payload_offset;
        logic [15:0] payload_size;
    } t_record;

endpackage

/* src/ipv4p_field_capture.sv */
module ipv4p_field_capture (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipv4p_pkg::t_step_ctrl i_ctrl,
    input  logic [7:0]           i_data_byte,
    input  logic [15:0]          i_wire_length,
    output ipv4p_pkg::t_record   o_record
);
    import ipv4p_pkg::*;

    logic [15:0] r_pos,      n_pos;
    logic [3:0]  r_ihl,      n_ihl;
    logic [7:0]  r_proto,    n_proto;
    logic [3:0]  r_tdw,      n_tdw;
    logic [47:0] r_mac_src,  n_mac_src;
    logic [47:0] r_mac_dst,  n_mac_dst;
    logic [31:0] r_ip_src,   n_ip_src;
    logic [31:0] r_ip_dst,   n_ip_dst;
    logic [15:0] r_port_src, n_port_src;
    logic [15:0] r_port_dst, n_port_dst;
    logic [5:0]  r_flags,    n_flags;
    logic [31:0] r_seq,      n_seq;

    logic [15:0] lh;
    logic        in_ip;
    logic [15:0] rel;
    logic [15:0] tp_start;
    logic        in_tp;
    logic [15:0] q;
    logic [7:0]  off;
    logic [1:0]  cls;
    logic        ported;
    logic        is_tcp;

    always_comb begin
        n_pos      = r_pos;
        n_ihl      = r_ihl;
        n_proto    = r_proto;
        n_tdw      = r_tdw;
        n_mac_src  = r_mac_src;
        n_mac_dst  = r_mac_dst;
        n_ip_src   = r_ip_src;
        n_ip_dst   = r_ip_dst;
        n_port_src = r_port_src;
        n_port_dst = r_port_dst;
        n_flags    = r_flags;
        n_seq      = r_seq;

        lh    = i_ctrl.eth ? ETH_HDR_LEN : 16'd0;
        in_ip = r_pos >= lh;
        rel   = r_pos - lh;

        if (i_ctrl.step && i_ctrl.capture) begin
            for (int k = 0; k < 6; k++) begin
                if (i_ctrl.eth && r_pos == 16'(k))
                    n_mac_dst[8*(5-k) +: 8] = r_mac_dst[8*(5-k) +: 8] | i_data_byte;
                if (i_ctrl.eth && r_pos == 16'(k + 6))
                    n_mac_src[8*(5-k) +: 8] = r_mac_src[8*(5-k) +: 8] | i_data_byte;
            end
            if (in_ip && rel == 16'd0)
                n_ihl = i_data_byte[3:0];
            if (in_ip && rel == 16'd9)
                n_proto = i_data_byte;
            for (int k = 0; k < 4; k++) begin
                if (in_ip && rel == 16'(12 + k))
                    n_ip_src[8*(3-k) +: 8] = r_ip_src[8*(3-k) +: 8] | i_data_byte;
                if (in_ip && rel == 16'(16 + k))
                    n_ip_dst[8*(3-k) +: 8] = r_ip_dst[8*(3-k) +: 8] | i_data_byte;
            end
        end

        // transport header starts 4*ihl after the ip header, ihl may arrive this byte
        tp_start = {10'd0, n_ihl, 2'b00};
        in_tp    = in_ip && (rel >= tp_start);
        q        = rel - tp_start;

        if (i_ctrl.step && i_ctrl.capture && in_tp) begin
            for (int k = 0; k < 2; k++) begin
                if (q == 16'(k))
                    n_port_src[8*(1-k) +: 8] = r_port_src[8*(1-k) +: 8] | i_data_byte;
                if (q == 16'(k + 2))
                    n_port_dst[8*(1-k) +: 8] = r_port_dst[8*(1-k) +: 8] | i_data_byte;
            end
            for (int k = 0; k < 4; k++) begin
                if (q == 16'(k + 4))
                    n_seq[8*(3-k) +: 8] = r_seq[8*(3-k) +: 8] | i_data_byte;
            end
            if (q == 16'd12)
                n_tdw = i_data_byte[7:4];
            if (q == 16'd13)
                n_flags = i_data_byte[5:0];
        end

        if (i_ctrl.step && r_pos != 16'hFFFF)
            n_pos = r_pos + 16'd1;

        // record from the state including this byte
        off = lh[7:0] + {2'b00, n_ihl, 2'b00};
        priority if (n_proto == PROTO_TCP) begin
            cls = CLASS_TCP;
            off = off + {2'b00, n_tdw, 2'b00};
        end else if (n_proto == PROTO_UDP) begin
            cls = CLASS_UDP;
            off = off + UDP_HDR_LEN;
        end else if (n_proto == PROTO_ICMP) begin
            cls = CLASS_ICMP;
        end else begin
            cls = CLASS_OTHER;
        end
        ported = (cls == CLASS_TCP) || (cls == CLASS_UDP);
        is_tcp = (cls == CLASS_TCP);

        o_record.proto_class    = cls;
        o_record.src_mac        = n_mac_src;
        o_record.dst_mac        = n_mac_dst;
        o_record.src_ip         = n_ip_src;
        o_record.dst_ip         = n_ip_dst;
        o_record.src_port       = ported ? n_port_src : 16'd0;
        o_record.dst_port       = ported ? n_port_dst : 16'd0;
        o_record.tcp_flag_bits  = is_tcp ? n_flags : 6'd0;
        o_record.tcp_seq        = is_tcp ? n_seq : 32'd0;
        o_record.payload_offset = off;
        o_record.payload_size   = ({8'd0, off} < i_wire_length) ?
                                  (i_wire_length - {8'd0, off}) : 16'd0;

        // packet done, start clean
        if (i_ctrl.step && i_ctrl.last) begin
            n_pos      = '0;
            n_ihl      = '0;
            n_proto    = '0;
            n_tdw      = '0;
            n_mac_src  = '0;
            n_mac_dst  = '0;
            n_ip_src   = '0;
            n_ip_dst   = '0;
            n_port_src = '0;
            n_port_dst = '0;
            n_flags    = '0;
            n_seq      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_ihl      <= '0;
            r_proto    <= '0;
            r_tdw      <= '0;
            r_mac_src  <= '0;
            r_mac_dst  <= '0;
            r_ip_src   <= '0;
            r_ip_dst   <= '0;
            r_port_src <= '0;
            r_port_dst <= '0;
            r_flags    <= '0;
            r_seq      <= '0;
        end else begin
            r_pos      <= n_pos;
            r_ihl      <= n_ihl;
            r_proto    <= n_proto;
            r_tdw      <= n_tdw;
            r_mac_src  <= n_mac_src;
            r_mac_dst  <= n_mac_dst;
            r_ip_src   <= n_ip_src;
            r_ip_dst   <= n_ip_dst;
            r_port_src <= n_port_src;
            r_port_dst <= n_port_dst;
            r_flags    <= n_flags;
            r_seq      <= n_seq;
        end
    end

endmodule

/* src/ipv4_transport_header_parser.sv */
// IPv4 transport header parser. Packet bytes come in one request per byte, in
// order, with the packet's wire length; the byte flagged last closes the packet
// and, if the link mode is supported, produces one record on the output channel:
// MAC addresses (ethernet mode only), IPv4 addresses, protocol class, TCP/UDP
// ports, TCP flags and sequence number, payload offset (link header included)
// and payload length (saturated at zero). Fields the packet never reached read
// zero. The link mode register sits at byte address 0 of the APB port
// (0 ethernet, 1 raw IPv4, 2 or 3 drop); change it only with no packet in flight.
// Throughput is one byte per clock cycle while the input side does not stall. A
// byte is held in the input register, where the per-packet field capture runs,
// and a last byte's record is loaded into the result register as that byte
// leaves the input register. The input side stalls only when a record is ready to
// be loaded while the result register still holds an untaken one.
module ipv4_transport_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // byte request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_wire_length,

    // record channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_proto_class,
    output logic [47:0] o_src_mac,
    output logic [47:0] o_dst_mac,
    output logic [31:0] o_src_ip,
    output logic [31:0] o_dst_ip,
    output logic [15:0] o_src_port,
    output logic [15:0] o_dst_port,
    output logic [5:0]  o_tcp_flag_bits,
    output logic [31:0] o_tcp_seq,
    output logic [7:0]  o_payload_offset,
    output logic [15:0] o_payload_size
);
    import ipv4p_pkg::*;

    // configuration
    logic [1:0]  r_link_mode;
    logic        cfg_wr;

    // input register
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;
    logic [15:0] r_s1_wlen;

    // result register
    logic        r_out_valid;
    t_record     r_rec;

    t_step_ctrl  ctrl;
    t_record     rec;
    logic        supported;
    logic        emits;
    logic        out_free;
    logic        s1_go;
    logic        in_accept;

    // apb: zero wait states, register index from the word address
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == CFG_IDX_LINK_MODE) ? {30'd0, r_link_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_mode <= LINK_ETH;
        end else if (cfg_wr && paddr[2] == CFG_IDX_LINK_MODE) begin
            r_link_mode <= pwdata[1:0];
        end
    end

    // handshake: bytes that make no record never wait on the output side
    assign supported  = (r_link_mode == LINK_ETH) || (r_link_mode == LINK_RAW);
    assign emits      = r_s1_last && supported;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (out_free || !emits);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last_byte;
            r_s1_wlen <= i_wire_length;
        end
    end

    // per-packet field capture and record build
    assign ctrl.step    = s1_go;
    assign ctrl.last    = r_s1_last;
    assign ctrl.capture = supported;
    assign ctrl.eth     = (r_link_mode == LINK_ETH);

    ipv4p_field_capture u_capture (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_data_byte   (r_s1_byte),
        .i_wire_length (r_s1_wlen),
        .o_record      (rec)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && emits) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && emits) begin
            r_rec <= rec;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_proto_class    = r_rec.proto_class;
    assign o_src_mac        = r_rec.src_mac;
    assign o_dst_mac        = r_rec.dst_mac;
    assign o_src_ip         = r_rec.src_ip;
    assign o_dst_ip         = r_rec.dst_ip;
    assign o_src_port       = r_rec.src_port;
    assign o_dst_port       = r_rec.dst_port;
    assign o_tcp_flag_bits  = r_rec.tcp_flag_bits;
    assign o_tcp_seq        = r_rec.tcp_seq;
    assign o_payload_offset = r_rec.payload_offset;
    assign o_payload_size   = r_rec.payload_size;

endmodule

/* src/ipv4p_checker.sv */
module ipv4p_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_in_stall,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  o_proto_class,
    input  logic [15:0] o_src_port,
    input  logic [15:0] o_dst_port,
    input  logic [5:0]  o_tcp_flag_bits,
    input  logic [31:0] o_tcp_seq,
    input  logic [7:0]  o_payload_offset,
    input  logic [47:0] o_src_mac
);
    import ipv4p_pkg::*;

    // a record waiting on a stall stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_src_mac)
            && $stable(o_payload_offset))
        else $error("record changed while stalled");

    // tcp-only fields are zero on non-tcp records
    a_tcp_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_proto_class != CLASS_TCP |-> o_tcp_seq == 32'd0
            && o_tcp_flag_bits == 6'd0)
        else $error("tcp fields set on non-tcp record");

    // ports only for tcp and udp
    a_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_proto_class == CLASS_ICMP || o_proto_class == CLASS_OTHER)
            |-> o_src_port == 16'd0 && o_dst_port == 16'd0)
        else $error("ports set on non-transport record");

    // offset never exceeds link + max ip + max tcp header
    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_payload_offset <= 8'(MAX_OFFSET))
        else $error("payload offset out of range");

    // no record and no input stall out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("record valid after reset");

endmodule

bind ipv4_transport_header_parser ipv4p_checker u_ipv4p_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_proto_class    (o_proto_class),
    .o_src_port       (o_src_port),
    .o_dst_port       (o_dst_port),
    .o_tcp_flag_bits  (o_tcp_flag_bits),
    .o_tcp_seq        (o_tcp_seq),
    .o_payload_offset (o_payload_offset),
    .o_src_mac        (o_src_mac)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import ipv4p_pkg::*;

    // drop modes have no package name, both values are exercised
    localparam logic [1:0] LINK_DROP    = 2'd2;
    localparam logic [1:0] LINK_DROP_HI = 2'd3;

    // word address of the link mode register on the apb port
    localparam logic [2:0] LINK_MODE_ADDR = {CFG_IDX_LINK_MODE, 2'b00};

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 1950;    // bytes sent in the random part
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_CAP     = 150;

    // how a side spaces its handshakes
    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} t_idle_mode;

    // one byte request as the driver holds it
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] wlen;
    } t_byte_req;

    // dut ports, all inputs driven to known values from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic [15:0] i_wire_length = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_proto_class;
    logic [47:0] o_src_mac;
    logic [47:0] o_dst_mac;
    logic [31:0] o_src_ip;
    logic [31:0] o_dst_ip;
    logic [15:0] o_src_port;
    logic [15:0] o_dst_port;
    logic [5:0]  o_tcp_flag_bits;
    logic [31:0] o_tcp_seq;
    logic [7:0]  o_payload_offset;
    logic [15:0] o_payload_size;

    // byte requests waiting for the driver, and records the parser still owes
    t_byte_req byte_requests[$];
    t_record   pending_records[$];

    // driver and monitor bookkeeping
    t_byte_req  cur_req = '0;
    logic       in_hold = 1'b0;         // mirrors i_in_valid
    int         gap_left = 0;
    t_idle_mode gap_mode = IDLE_FULL;
    int         stall_left = 0;
    t_idle_mode stall_mode = IDLE_SPARSE;
    int         records_seen = 0;
    int         mismatches = 0;
    int         cycle_count = 0;

    // predictor copy of the link mode register and of the per-packet state
    logic [1:0]  link_mode_mirror = LINK_ETH;
    logic [15:0] pos_cnt = '0;
    logic [3:0]  ihl_acc = '0;
    logic [7:0]  proto_acc = '0;
    logic [3:0]  doff_acc = '0;
    logic [47:0] mac_src_acc = '0;
    logic [47:0] mac_dst_acc = '0;
    logic [31:0] ip_src_acc = '0;
    logic [31:0] ip_dst_acc = '0;
    logic [15:0] port_src_acc = '0;
    logic [15:0] port_dst_acc = '0;
    logic [5:0]  flags_acc = '0;
    logic [31:0] seq_acc = '0;

    ipv4_transport_header_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_wire_length    (i_wire_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_proto_class    (o_proto_class),
        .o_src_mac        (o_src_mac),
        .o_dst_mac        (o_dst_mac),
        .o_src_ip         (o_src_ip),
        .o_dst_ip         (o_dst_ip),
        .o_src_port       (o_src_port),
        .o_dst_port       (o_dst_port),
        .o_tcp_flag_bits  (o_tcp_flag_bits),
        .o_tcp_seq        (o_tcp_seq),
        .o_payload_offset (o_payload_offset),
        .o_payload_size   (o_payload_size)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ipv4_transport_header_parser verification failed");
            $finish;
        end
    end

    // cycles a side waits before its next handshake
    function automatic int draw_wait(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return int'($urandom_range(0, 11));
            default:   return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 11)) : 0;
        endcase
    endfunction

    // header field tracker: takes one accepted byte, owes a record on a supported last byte
    function automatic void track_header_byte(input t_byte_req req);
        bit      eth;
        bit      supported;
        int      hdr;
        int      p;
        int      r;
        int      q;
        int      off;
        t_record rec;
        // link mode is sampled on every byte, a mid-packet change takes effect at once
        eth = (link_mode_mirror == LINK_ETH);
        supported = eth || (link_mode_mirror == LINK_RAW);
        hdr = eth ? int'(ETH_HDR_LEN) : 0;
        p = int'(pos_cnt);
        if (supported) begin
            // mac addresses, first byte on the wire most significant
            if (eth && p < 6) mac_dst_acc |= 48'(req.data) << (8 * (5 - p));
            else if (eth && p < 12) mac_src_acc |= 48'(req.data) << (8 * (11 - p));
            if (p >= hdr) begin
                r = p - hdr;
                if (r == 0) ihl_acc = req.data[3:0];
                if (r == 9) proto_acc = req.data;
                if (r >= 12 && r < 16) ip_src_acc |= 32'(req.data) << (8 * (15 - r));
                if (r >= 16 && r < 20) ip_dst_acc |= 32'(req.data) << (8 * (19 - r));
                // transport header follows 4*ihl bytes, even for ihl below five,
                // so one byte can land in an ip field and a transport field
                if (r >= 4 * int'(ihl_acc)) begin
                    q = r - 4 * int'(ihl_acc);
                    if (q < 2) port_src_acc |= 16'(req.data) << (8 * (1 - q));
                    else if (q < 4) port_dst_acc |= 16'(req.data) << (8 * (3 - q));
                    else if (q < 8) seq_acc |= 32'(req.data) << (8 * (7 - q));
                    else if (q == 12) doff_acc = req.data[7:4];
                    else if (q == 13) flags_acc = req.data[5:0];
                end
            end
        end
        // saturating position, out of reach of every field anyway
        if (pos_cnt != 16'hFFFF) pos_cnt++;
        if (!req.last) return;

        if (supported) begin
            rec = '0;
            off = hdr + 4 * int'(ihl_acc);
            case (proto_acc)
                PROTO_TCP: begin
                    rec.proto_class = CLASS_TCP;
                    off += 4 * int'(doff_acc);
                end
                PROTO_UDP: begin
                    rec.proto_class = CLASS_UDP;
                    off += int'(UDP_HDR_LEN);
                end
                PROTO_ICMP: rec.proto_class = CLASS_ICMP;
                default: rec.proto_class = CLASS_OTHER;
            endcase
            rec.src_mac = mac_src_acc;
            rec.dst_mac = mac_dst_acc;
            rec.src_ip = ip_src_acc;
            rec.dst_ip = ip_dst_acc;
            if (rec.proto_class == CLASS_TCP || rec.proto_class == CLASS_UDP) begin
                rec.src_port = port_src_acc;
                rec.dst_port = port_dst_acc;
            end
            if (rec.proto_class == CLASS_TCP) begin
                rec.tcp_flag_bits = flags_acc;
                rec.tcp_seq = seq_acc;
            end
            rec.payload_offset = 8'(off);
            // payload length saturates at zero when the offset reaches the wire length
            rec.payload_size = (off < int'(req.wlen)) ? 16'(int'(req.wlen) - off) : '0;
            pending_records = {pending_records, rec};
        end

        // per-packet state clears on every last byte, dropped packets too
        pos_cnt = '0;
        ihl_acc = '0;
        proto_acc = '0;
        doff_acc = '0;
        mac_src_acc = '0;
        mac_dst_acc = '0;
        ip_src_acc = '0;
        ip_dst_acc = '0;
        port_src_acc = '0;
        port_dst_acc = '0;
        flags_acc = '0;
        seq_acc = '0;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP) $display("%0t ns: %s", $realtime, msg);
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("record %0d: %s is %0h, expected %0h",
                                      records_seen, name, got, want));
    endtask

    // byte driver: holds a request until accepted, then waits its drawn gap
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_hold && !o_in_stall) begin
                track_header_byte(cur_req);
                in_hold = 1'b0;
            end
            if (!in_hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (byte_requests.size() > 0) begin
                    cur_req = byte_requests.pop_front();
                    in_hold = 1'b1;
                    gap_left = draw_wait(gap_mode);
                    // switch between bursts, full idling and sparse idling now and then
                    if ($urandom_range(0, 39) == 0) gap_mode = t_idle_mode'($urandom_range(0, 2));
                end
            end
            // valid written once per edge, payload only moves on a new request
            i_in_valid <= in_hold;
            i_data_byte <= cur_req.data;
            i_last_byte <= cur_req.last;
            i_wire_length <= cur_req.wlen;
        end
    end

    // record monitor: checks every taken record, then stalls for a drawn count
    always @(posedge i_clk) begin : record_monitor
        t_record got;
        t_record want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.proto_class = o_proto_class;
                got.src_mac = o_src_mac;
                got.dst_mac = o_dst_mac;
                got.src_ip = o_src_ip;
                got.dst_ip = o_dst_ip;
                got.src_port = o_src_port;
                got.dst_port = o_dst_port;
                got.tcp_flag_bits = o_tcp_flag_bits;
                got.tcp_seq = o_tcp_seq;
                got.payload_offset = o_payload_offset;
                got.payload_size = o_payload_size;
                if (pending_records.size() == 0) begin
                    report_mismatch($sformatf("record %0d arrived with none owed", records_seen));
                end else begin
                    want = pending_records.pop_front();
                    cmp_field("proto_class", 64'(got.proto_class), 64'(want.proto_class));
                    cmp_field("src_mac", 64'(got.src_mac), 64'(want.src_mac));
                    cmp_field("dst_mac", 64'(got.dst_mac), 64'(want.dst_mac));
                    cmp_field("src_ip", 64'(got.src_ip), 64'(want.src_ip));
                    cmp_field("dst_ip", 64'(got.dst_ip), 64'(want.dst_ip));
                    cmp_field("src_port", 64'(got.src_port), 64'(want.src_port));
                    cmp_field("dst_port", 64'(got.dst_port), 64'(want.dst_port));
                    cmp_field("tcp_flag_bits", 64'(got.tcp_flag_bits), 64'(want.tcp_flag_bits));
                    cmp_field("tcp_seq", 64'(got.tcp_seq), 64'(want.tcp_seq));
                    cmp_field("payload_offset", 64'(got.payload_offset),
                              64'(want.payload_offset));
                    cmp_field("payload_size", 64'(got.payload_size),
                              64'(want.payload_size));
                end
                records_seen++;
                stall_left = draw_wait(stall_mode);
                if ($urandom_range(0, 7) == 0) stall_mode = t_idle_mode'($urandom_range(0, 2));
            end
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // wait until every request is taken and every record is in, then let the pipe drain
    task automatic settle();
        do @(negedge i_clk);
        while (byte_requests.size() != 0 || in_hold || pending_records.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write: setup cycle, access cycle, register takes the data with pready high
    task automatic set_link_mode(input logic [1:0] mode);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LINK_MODE_ADDR;
        pwdata <= 32'(mode);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        link_mode_mirror = mode;
    endtask

    task automatic queue_bytes(input logic [7:0] octets[$], input logic [15:0] wlen,
                               input bit ends);
        t_byte_req req;
        foreach (octets[i]) begin
            req.data = octets[i];
            req.last = ends && (i == octets.size() - 1);
            req.wlen = wlen;
            byte_requests = {byte_requests, req};
        end
    endtask

    // one packet: mostly well formed headers with random content, some noise,
    // some cut short, wire length mostly honest but sometimes short or wild
    task automatic build_packet(input bit eth, output logic [7:0] pkt[$],
                                output logic [15:0] wlen);
        int         hdr;
        int         ihl;
        int         doff;
        int         tp_len;
        int         full_len;
        int         pick;
        int         idx;
        int         cut;
        logic [7:0] proto;
        pkt = {};
        if ($urandom_range(0, 9) == 0) begin
            // noise, mostly too short to reach the transport header
            repeat ($urandom_range(1, 40)) pkt = {pkt, 8'($urandom)};
            wlen = 16'($urandom);
            return;
        end
        hdr = eth ? int'(ETH_HDR_LEN) : 0;
        ihl = ($urandom_range(0, 3) != 0) ? 5 : int'($urandom_range(0, 15));
        doff = ($urandom_range(0, 3) != 0) ? 5 : int'($urandom_range(0, 15));
        pick = int'($urandom_range(0, 19));
        proto = (pick < 8) ? PROTO_TCP : (pick < 14) ? PROTO_UDP :
                (pick < 17) ? PROTO_ICMP : 8'($urandom);
        if (proto == PROTO_TCP) tp_len = (4 * doff > 14) ? 4 * doff : 14;
        else if (proto == PROTO_UDP || proto == PROTO_ICMP) tp_len = 8;
        else tp_len = int'($urandom_range(0, 12));
        full_len = hdr + 4 * ihl + tp_len + int'($urandom_range(0, 4));
        if (full_len < hdr + 20) full_len = hdr + 20;
        repeat (full_len) pkt = {pkt, 8'($urandom)};
        // version nibble is not checked, usually 4
        pkt[hdr] = {(($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'h4), 4'(ihl)};
        pkt[hdr + 9] = proto;
        if (proto == PROTO_TCP) begin
            idx = hdr + 4 * ihl + 12;
            pkt[idx] = {4'(doff), pkt[idx][3:0]};
        end
        // truncated capture
        if ($urandom_range(0, 6) == 0) begin
            cut = int'($urandom_range(1, full_len));
            while (pkt.size() > cut) void'(pkt.pop_back());
        end
        pick = int'($urandom_range(0, 9));
        if (pick < 6) wlen = 16'(full_len);
        else if (pick < 8) wlen = 16'(full_len + int'($urandom_range(0, 1500)));
        else if (pick == 8) wlen = 16'($urandom);
        else wlen = 16'($urandom_range(0, hdr + 4 * ihl + 30));
    endtask

    initial begin : stimulus
        logic [7:0]  pkt[$];
        logic [15:0] wlen;
        logic [1:0]  mode;
        bit          supported;
        int          items_sent;
        int          phase;
        int          pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // mode change mid packet: two mac bytes in ethernet mode, the rest raw
        pkt = {8'hFF, 8'h00};
        queue_bytes(pkt, 16'hFFFF, 1'b0);
        settle();
        set_link_mode(LINK_RAW);
        // ihl byte already passed, protocol lands as icmp, wire length zero
        pkt = {8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'hFF, PROTO_ICMP};
        queue_bytes(pkt, 16'h0000, 1'b1);

        // raw tcp with ihl zero: ports overlap the ip header, widest data offset,
        // every flag set, largest wire length
        pkt = {8'h40, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC,
               PROTO_TCP, 8'h00, 8'hFF, 8'hF0, 8'hFF};
        queue_bytes(pkt, 16'hFFFF, 1'b1);

        // top link mode value drops the packet
        settle();
        set_link_mode(LINK_DROP_HI);
        pkt = {8'hFF};
        queue_bytes(pkt, 16'hFFFF, 1'b1);

        // random phases, each under one link mode setting
        items_sent = 0;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = int'($urandom_range(0, 19));
            if (phase == 0) mode = LINK_DROP;
            else if (phase == 1) mode = LINK_ETH;
            else if (pick < 9) mode = LINK_ETH;
            else if (pick < 17) mode = LINK_RAW;
            else if (pick < 19) mode = LINK_DROP;
            else mode = LINK_DROP_HI;
            settle();
            set_link_mode(mode);
            supported = (mode == LINK_ETH) || (mode == LINK_RAW);
            repeat (supported ? $urandom_range(3, 10) : $urandom_range(1, 2)) begin
                build_packet(supported ? (mode == LINK_ETH) : bit'($urandom_range(0, 1)),
                             pkt, wlen);
                queue_bytes(pkt, wlen, 1'b1);
                items_sent += pkt.size();
            end
            phase++;
        end

        settle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("ipv4_transport_header_parser verification clean");
        end else begin
            $display("ipv4_transport_header_parser verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/ipv4p_pkg.sv
src/ipv4p_field_capture.sv
src/ipv4_transport_header_parser.sv
src/ipv4p_checker.sv
tb/sv/tb_top.sv
